/* hw/rtl/c2rb_pkg.sv */
// ----------------------------------------------------------------------------
// c2rb_pkg
// Shared types and constants for the CIGAR to reference block converter.
// ----------------------------------------------------------------------------
package c2rb_pkg;

    localparam int CHAR_W = 8;
    localparam int RUN_W  = 32;
    localparam int OUT_W  = 32;
    localparam int THR_W  = 16;
    localparam int START_W = 32;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9 = 8'h39;
    localparam logic [CHAR_W-1:0] OP_M   = 8'h4D;
    localparam logic [CHAR_W-1:0] OP_X   = 8'h58;
    localparam logic [CHAR_W-1:0] OP_D   = 8'h44;
    localparam logic [CHAR_W-1:0] OP_N   = 8'h4E;
    localparam logic [CHAR_W-1:0] OP_I   = 8'h49;
    localparam logic [CHAR_W-1:0] OP_S   = 8'h53;
    localparam logic [CHAR_W-1:0] OP_H   = 8'h48;

    localparam logic [THR_W-1:0] SPLIT_THR_RESET = 16'd20;

    // One input character request
    typedef struct packed {
        logic                last_char;
        logic [START_W-1:0]  read_ref_start;
        logic                first_char;
        logic [CHAR_W-1:0]   cigar_char;
    } item_t;

    // One aligned block
    typedef struct packed {
        logic              final_block;
        logic [OUT_W-1:0]  block_finish;
        logic [OUT_W-1:0]  block_begin;
    } block_t;

    // Results produced by one character: a closed block, then a final block
    typedef struct packed {
        logic    closed_valid;
        block_t  closed;
        logic    final_valid;
        block_t  fin;
    } step_res_t;

endpackage

/* hw/rtl/cigar_to_reference_blocks.sv */
// ----------------------------------------------------------------------------
// cigar_to_reference_blocks
// A character request is held in the input register, then its blocks are
// written into the result queue. Throughput: one character per cycle while
// the queue has room for two; the single-read queue hands blocks out one at a time.
// Reset (aresetn low, synchronous): cursor, open block start, run length and
// queue are cleared; the split threshold returns to 20.
// ----------------------------------------------------------------------------
module cigar_to_reference_blocks
    import c2rb_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,

    // Configuration
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,     // deletion_split_threshold

    // Character stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // [7:0] cigar_char, [39:8] read_ref_start
    input  logic         s_axis_tuser,  // first_char
    input  logic         s_axis_tlast,  // last_char

    // Block stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // [31:0] block_begin, [63:32] block_finish
    output logic         m_axis_tlast   // final_block
);

    logic [THR_W-1:0]  split_thr_reg;
    logic              in_valid_reg, in_valid_next;
    item_t             in_reg;
    logic              in_accept;
    logic              advance;
    logic              room2;
    step_res_t         step_res;
    block_t            out_block;

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_thr_reg <= SPLIT_THR_RESET;
        end else if (cfg_we) begin
            split_thr_reg <= cfg_wdata;
        end
    end

    // Input register
    assign advance       = in_valid_reg && room2;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_reg.cigar_char     <= s_axis_tdata[7:0];
            in_reg.read_ref_start <= s_axis_tdata[39:8];
            in_reg.first_char     <= s_axis_tuser;
            in_reg.last_char      <= s_axis_tlast;
        end
    end

    // Character decode and state
    c2rb_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .item      (in_reg),
        .split_thr (split_thr_reg),
        .res       (step_res)
    );

    // Result queue
    c2rb_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_res  (step_res),
        .push_en   (advance),
        .room2     (room2),
        .out_valid (m_axis_tvalid),
        .out_block (out_block),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out_block.block_finish, out_block.block_begin};
    assign m_axis_tlast = out_block.final_block;

endmodule

/* hw/rtl/c2rb_core.sv */
// ----------------------------------------------------------------------------
// c2rb_core
// Run length, reference cursor and open block state; decodes one character
// per cycle while step_en is high and produces up to two blocks.
// ----------------------------------------------------------------------------
module c2rb_core
    import c2rb_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  item_t             item,
    input  logic [THR_W-1:0]  split_thr,
    output step_res_t         res
);

    logic [RUN_W-1:0]     run_reg,    run_next;
    logic [POS_WIDTH-1:0] cursor_reg, cursor_next;
    logic [POS_WIDTH-1:0] open_reg,   open_next;

    logic [POS_WIDTH-1:0] load_pos;
    logic [POS_WIDTH-1:0] cur_base;
    logic [POS_WIDTH-1:0] open_base;
    logic [RUN_W-1:0]     run_base;
    logic [POS_WIDTH-1:0] len_pos;
    logic [POS_WIDTH-1:0] cur_adv;
    logic [RUN_W+3:0]     run_prod;
    logic [RUN_W-1:0]     run_sat;
    logic                 is_digit;
    logic                 move;
    logic                 split;
    logic [63:0]          start_wide;
    logic [63:0]          len_wide;

    // Position to output width (zero extend or truncate)
    function automatic logic [OUT_W-1:0] to_out(input logic [POS_WIDTH-1:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[OUT_W-1:0];
    endfunction

    // New read reloads the cursor, open block and run
    assign start_wide = 64'(item.read_ref_start);
    assign load_pos   = start_wide[POS_WIDTH-1:0];
    assign cur_base   = item.first_char ? load_pos : cursor_reg;
    assign open_base  = item.first_char ? load_pos : open_reg;
    assign run_base   = item.first_char ? '0 : run_reg;

    assign len_wide = 64'(run_base);
    assign len_pos  = len_wide[POS_WIDTH-1:0];
    assign cur_adv  = cur_base + len_pos;

    assign is_digit = (item.cigar_char >= CHAR_0) && (item.cigar_char <= CHAR_9);

    // run * 10 + digit, saturating at all ones
    assign run_prod = ((RUN_W+4)'(run_base) << 3) + ((RUN_W+4)'(run_base) << 1)
                    + (RUN_W+4)'(item.cigar_char - CHAR_0);
    assign run_sat  = (run_prod[RUN_W+3:RUN_W] != '0) ? '1 : run_prod[RUN_W-1:0];

    // Operation decode
    always_comb begin
        move  = 1'b0;
        split = 1'b0;
        unique case (item.cigar_char)
            OP_M, OP_X: begin
                move = 1'b1;
            end
            OP_D: begin
                move  = 1'b1;
                split = run_base > RUN_W'(split_thr);
            end
            OP_N: begin
                move  = 1'b1;
                split = 1'b1;
            end
            OP_I, OP_S, OP_H: begin
                move = 1'b0;
            end
            default: begin
                move = 1'b0;
            end
        endcase
        if (is_digit) begin
            move  = 1'b0;
            split = 1'b0;
        end
    end

    // Next state
    always_comb begin
        cursor_next = move  ? cur_adv : cur_base;
        open_next   = split ? cur_adv : open_base;
        if (item.last_char || !is_digit) begin
            run_next = '0;
        end else begin
            run_next = run_sat;
        end
    end

    // Results: block closed by D/N, then final block on the last character
    always_comb begin
        res.closed_valid           = split;
        res.closed.block_begin     = to_out(open_base);
        res.closed.block_finish    = to_out(cur_base);
        res.closed.final_block     = 1'b0;
        res.final_valid            = item.last_char;
        res.fin.block_begin        = to_out(open_next);
        res.fin.block_finish       = to_out(cursor_next);
        res.fin.final_block        = 1'b1;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= '0;
            cursor_reg <= '0;
            open_reg   <= '0;
        end else if (step_en) begin
            run_reg    <= run_next;
            cursor_reg <= cursor_next;
            open_reg   <= open_next;
        end
    end

endmodule

/* hw/rtl/c2rb_outq.sv */
// ----------------------------------------------------------------------------
// c2rb_outq
// Four-entry result queue: takes up to two blocks per cycle, hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module c2rb_outq
    import c2rb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  step_res_t  push_res,
    input  logic       push_en,
    output logic       room2,
    output logic       out_valid,
    output block_t     out_block,
    input  logic       out_ready
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    block_t             q_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;

    logic               wr0, wr1;
    block_t             wdata0;
    logic [PTR_W-1:0]   wr_ptr_p1;
    logic               pop;
    logic [CNT_W-1:0]   n_push;

    assign room2     = cnt_reg <= CNT_W'(DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_block = q_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Closed block goes first; final block fills the next slot
    assign wr0       = push_en && (push_res.closed_valid || push_res.final_valid);
    assign wr1       = push_en && push_res.closed_valid && push_res.final_valid;
    assign wdata0    = push_res.closed_valid ? push_res.closed : push_res.fin;
    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);
    assign n_push    = CNT_W'(wr0) + CNT_W'(wr1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        cnt_next    = cnt_reg + n_push - CNT_W'(pop);
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (wr0) begin
            q_reg[wr_ptr_reg] <= wdata0;
        end
        if (wr1) begin
            q_reg[wr_ptr_p1] <= push_res.fin;
        end
    end

endmodule

/* test/cigar_to_reference_blocks_tb.sv */
// ----------------------------------------------------------------------------
// cigar_to_reference_blocks_tb
// Streams CIGAR characters into the block converter and checks every block
// it returns against a cycle-free model of the parser kept in the bench.
// A short directed read set comes first. Random reads and noise characters
// follow under three split thresholds and three idle patterns. One long
// receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module cigar_to_reference_blocks_tb
    import c2rb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD  = 6;
    localparam int          ITEMS_PHASE  = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SETTLE       = 8;
    localparam int          LIMIT_CYCLES = 300000;
    localparam logic [63:0] RUN_MAX      = 64'hFFFF_FFFF;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [15:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // [7:0] cigar_char, [39:8] read_ref_start
    logic        s_axis_tuser  = 1'b0; // first_char
    logic        s_axis_tlast  = 1'b0; // last_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // [31:0] block_begin, [63:32] block_finish
    logic        m_axis_tlast;         // final_block

    cigar_to_reference_blocks dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Parser copy: threshold, run length, cursor, open block start
    logic [15:0] split_thr = SPLIT_THR_RESET;
    logic [63:0] run_len   = '0;
    logic [31:0] ref_pos   = '0;
    logic [31:0] blk_start = '0;

    item_t       chars_pending[$];
    block_t      blocks_due[$];
    logic [7:0]  read_chars[$];
    item_t       in_flight;

    int chars_queued  = 0;
    int chars_taken   = 0;
    int reads_queued  = 0;
    int blocks_seen   = 0;
    int splits_seen   = 0;
    int mismatches    = 0;
    int send_idle_pct = 35;
    int recv_idle_pct = 46;
    int stall_asks    = 0;
    int stall_seen    = 0;
    int stall_left    = 0;

    logic [7:0] op_codes[7] = '{OP_M, OP_X, OP_D, OP_N, OP_I, OP_S, OP_H};

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    // Blocks one accepted character gives: a closed block, then the final one
    task automatic predict_blocks(input item_t it);
        logic [63:0] digit;
        logic [63:0] len;
        logic        split;
        logic        moves;
        if (it.first_char) begin
            ref_pos   = it.read_ref_start;
            blk_start = ref_pos;
            run_len   = '0;
        end
        if (it.cigar_char >= CHAR_0 && it.cigar_char <= CHAR_9) begin
            digit = 64'(it.cigar_char - CHAR_0);
            if (run_len > (RUN_MAX - digit) / 10)
                run_len = RUN_MAX;
            else
                run_len = run_len * 10 + digit;
        end else begin
            len   = run_len;
            split = 1'b0;
            moves = 1'b0;
            case (it.cigar_char)
                OP_M, OP_X: begin
                    moves = 1'b1;
                end
                OP_D: begin
                    moves = 1'b1;
                    split = (len > 64'(split_thr));
                end
                OP_N: begin
                    moves = 1'b1;
                    split = 1'b1;
                end
                default: begin
                end
            endcase
            if (split)
                blocks_due.push_back('{final_block: 1'b0, block_finish: ref_pos,
                                       block_begin: blk_start});
            if (moves)
                ref_pos = ref_pos + len[31:0];
            if (split)
                blk_start = ref_pos;
            run_len = '0;
        end
        if (it.last_char) begin
            blocks_due.push_back('{final_block: 1'b1, block_finish: ref_pos,
                                   block_begin: blk_start});
            run_len = '0;
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic first,
                             input logic [31:0] start, input logic last);
        item_t it;
        it.cigar_char     = c;
        it.first_char     = first;
        it.read_ref_start = start;
        it.last_char      = last;
        chars_pending.push_back(it);
        chars_queued++;
    endtask

    // Decimal count for one operation, sometimes absent or saturating
    task automatic add_count();
        int          pick;
        int          nd;
        logic [63:0] val;
        logic [7:0]  digs[$];
        pick = $urandom_range(99);
        if (pick < 6)
            return;
        if (pick < 11) begin
            nd = $urandom_range(13, 10);
            read_chars.push_back(CHAR_9);
            repeat (nd - 1) read_chars.push_back(8'(CHAR_0 + $urandom_range(9)));
            return;
        end
        if (pick < 56)
            val = $urandom_range(40);
        else if (pick < 85)
            val = $urandom_range(999);
        else
            val = $urandom_range(150000);
        do begin
            digs.push_front(8'(CHAR_0 + val % 10));
            val = val / 10;
        end while (val != 0);
        foreach (digs[i]) read_chars.push_back(digs[i]);
    endtask

    // One read with random counts and operations, sometimes a non-digit noise byte
    task automatic queue_read();
        int          n_ops;
        logic [31:0] start;
        logic [7:0]  c;
        read_chars.delete();
        if ($urandom_range(4) == 0)
            start = 32'hFFFF_FF00 | $urandom_range(255);
        else
            start = $urandom;
        n_ops = $urandom_range(6, 1);
        repeat (n_ops) begin
            add_count();
            if ($urandom_range(19) == 0) begin
                do c = 8'($urandom); while (c >= CHAR_0 && c <= CHAR_9);
                read_chars.push_back(c);
            end else begin
                read_chars.push_back(op_codes[$urandom_range(6)]);
            end
        end
        // dangling count that no letter applies
        if ($urandom_range(6) == 0)
            add_count();
        foreach (read_chars[i])
            push_char(read_chars[i], i == 0, (i == 0) ? start : 32'($urandom),
                      i == read_chars.size() - 1);
        reads_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (chars_taken != chars_queued || blocks_due.size() != 0);
    endtask

    task automatic write_threshold(input logic [15:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        split_thr = v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Character driver: predicts on accept, then offers the next request
    always @(posedge aclk) begin
        item_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_blocks(in_flight);
                chars_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (chars_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = chars_pending.pop_front();
                    in_flight = nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {nxt.read_ref_start, nxt.cigar_char};
                    s_axis_tuser  <= nxt.first_char;
                    s_axis_tlast  <= nxt.last_char;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Block receiver: random idling, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (stall_seen != stall_asks) begin
            stall_seen = stall_asks;
            stall_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Block monitor: compare against the oldest predicted block
    always @(posedge aclk) begin
        block_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            blocks_seen++;
            if (blocks_due.size() == 0) begin
                report_mismatch("block with none expected", m_axis_tdata[31:0], '0);
            end else begin
                want = blocks_due.pop_front();
                if (!want.final_block)
                    splits_seen++;
                if (m_axis_tdata[31:0] !== want.block_begin)
                    report_mismatch("block_begin", m_axis_tdata[31:0], want.block_begin);
                if (m_axis_tdata[63:32] !== want.block_finish)
                    report_mismatch("block_finish", m_axis_tdata[63:32], want.block_finish);
                if (m_axis_tlast !== want.final_block)
                    report_mismatch("final_block", 32'(m_axis_tlast), 32'(want.final_block));
            end
        end
    end

    // Stimulus and phase sequencing
    initial begin
        logic [15:0] thr_list[3];
        int          target;
        thr_list = '{16'd0, 16'hFFFF, 16'($urandom_range(60))};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // 10M 21D 20D 5N from 100, at the reset threshold: D over it splits,
        // D at it does not, N on the last character gives two blocks
        push_char(8'(CHAR_0 + 1), 1'b1, 32'd100, 1'b0);
        push_char(CHAR_0,         1'b0, $urandom, 1'b0);
        push_char(OP_M,           1'b0, $urandom, 1'b0);
        push_char(8'(CHAR_0 + 2), 1'b0, $urandom, 1'b0);
        push_char(8'(CHAR_0 + 1), 1'b0, $urandom, 1'b0);
        push_char(OP_D,           1'b0, $urandom, 1'b0);
        push_char(8'(CHAR_0 + 2), 1'b0, $urandom, 1'b0);
        push_char(CHAR_0,         1'b0, $urandom, 1'b0);
        push_char(OP_D,           1'b0, $urandom, 1'b0);
        push_char(8'(CHAR_0 + 5), 1'b0, $urandom, 1'b0);
        push_char(OP_N,           1'b0, $urandom, 1'b1);
        // letter with no count, cursor wrap past the top, S H I, a non-letter
        // byte, and a trailing digit on the last character
        push_char(OP_X,           1'b1, 32'hFFFF_FFF0, 1'b0);
        push_char(8'(CHAR_0 + 3), 1'b0, $urandom, 1'b0);
        push_char(CHAR_0,         1'b0, $urandom, 1'b0);
        push_char(OP_X,           1'b0, $urandom, 1'b0);
        push_char(OP_S,           1'b0, $urandom, 1'b0);
        push_char(OP_H,           1'b0, $urandom, 1'b0);
        push_char(OP_I,           1'b0, $urandom, 1'b0);
        push_char(8'hFF,          1'b0, $urandom, 1'b0);
        push_char(8'(CHAR_0 + 7), 1'b0, $urandom, 1'b1);
        // count past 32 bits saturates, then a splitting D on the last character
        push_char(8'(CHAR_0 + 5), 1'b1, 32'd5, 1'b0);
        repeat (9) push_char(CHAR_9, 1'b0, $urandom, 1'b0);
        push_char(OP_D,           1'b0, $urandom, 1'b1);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            // the last character of a read may still be in flight
            repeat (SETTLE) @(posedge aclk);
            write_threshold(thr_list[ph]);
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 46 : 0;
            recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 35 : 0;
            target = chars_queued + ITEMS_PHASE;
            while (chars_queued < target) begin
                if ($urandom_range(9) == 0)
                    push_char(8'($urandom), 1'($urandom), $urandom, 1'($urandom));
                else
                    queue_read();
            end
            if (ph == 2)
                stall_asks++;
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (blocks_due.size() != 0)
            report_mismatch("blocks never returned", 32'(blocks_due.size()), '0);
        $display("Covered %0d characters in %0d random reads plus noise and directed reads,",
                 chars_taken, reads_queued);
        $display("%0d blocks checked (%0d split by D or N), thresholds 20, 0, 65535, %0d",
                 blocks_seen, splits_seen, thr_list[2]);
        if (mismatches == 0)
            $display("cigar_to_reference_blocks_tb passed");
        else
            $display("cigar_to_reference_blocks_tb failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(2 * HALF_PERIOD * LIMIT_CYCLES);
        $display("Timeout with %0d characters queued, %0d blocks outstanding",
                 chars_pending.size(), blocks_due.size());
        $display("cigar_to_reference_blocks_tb failed");
        $finish;
    end

endmodule
